// File: rtl/i2cbb_pkg.sv
`default_nettype none

package i2cbb_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int ACTION_W      = 3;
    localparam int BYTE_W        = 8;
    localparam int DELAY_W       = 10;
    localparam int BIT_IDX_W     = 4;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 8;

    localparam int QUEUE_DEPTH_DEF = 2;

    // Command codes carried in the action field.
    localparam logic [ACTION_W-1:0] ACT_START    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_STOP     = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_WRITE    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_READ     = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_ACK      = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_NACK     = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_WAIT_ACK = 3'd6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_US   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_WAIT_LIMIT = 2'd1;

    localparam logic [CFG_DATA_W-1:0] TICKS_PER_US_RST   = 8'd1;
    localparam logic [CFG_DATA_W-1:0] ACK_WAIT_LIMIT_RST = 8'd200;

    typedef struct packed {
        logic                launch;
        logic [ACTION_W-1:0] action;
        logic [BYTE_W-1:0]   tx_byte;
        logic                sda_sample;
    } t_item;

    typedef struct packed {
        logic              scl_level;
        logic              sda_level;
        logic              sda_drive;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] rx_byte;
        logic              no_ack;
    } t_res;

endpackage

`default_nettype wire

// File: rtl/i2cbb_if.sv
`default_nettype none

interface i2cbb_cmd_if;
    import i2cbb_pkg::*;
    logic                valid;
    logic                ready;
    logic                cmd_valid;
    logic [ACTION_W-1:0] action;
    logic [BYTE_W-1:0]   tx_byte;
    logic                sda_sample;

    modport source (output valid, cmd_valid, action, tx_byte, sda_sample, input ready);
    modport sink   (input valid, cmd_valid, action, tx_byte, sda_sample, output ready);
endinterface

interface i2cbb_res_if;
    import i2cbb_pkg::*;
    logic              valid;
    logic              ready;
    logic              scl_level;
    logic              sda_level;
    logic              sda_drive;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] rx_byte;
    logic              no_ack;

    modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                    rx_byte, no_ack, input ready);
    modport sink   (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                    rx_byte, no_ack, output ready);
endinterface

interface i2cbb_cfg_if;
    import i2cbb_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/i2c_bit_bang_master_unit.sv
// I2C master pin sequencer, stepped by one input word per bus tick.
// i_cmd carries one word per tick: a command flag with its action code and
// write byte, plus the sampled SDA level. o_res returns exactly one word per
// input word: SCL level, SDA level and direction, busy and done flags, the
// last read byte and the last acknowledge-timeout flag. i_cfg writes
// register 0 (ticks per microsecond) and register 1 (acknowledge polls);
// it is always ready and should be written only while no word is in flight.
// A front queue takes and decodes input words; the back sequencer applies
// one word per cycle to the bus state while o_res does not stall, and
// registers the result word. Throughput is one word per cycle while o_res
// does not stall. A taken input word waits in the queue, then its result
// word is registered in the output register, where it is valid until taken.
// When o_res stalls, the output register holds its word and the queue fills;
// i_cmd.ready drops once QUEUE_DEPTH words are waiting.
// Reset empties the queue, returns the sequencer to idle with SCL and SDA
// driven high, clears the read byte and the timeout flag, and restores the
// registers to one tick per microsecond and 200 polls.
`default_nettype none

module i2c_bit_bang_master_unit #(
    parameter int QUEUE_DEPTH = i2cbb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    i2cbb_cmd_if.sink    i_cmd,
    i2cbb_cfg_if.sink    i_cfg,
    i2cbb_res_if.source  o_res
);
    import i2cbb_pkg::*;

    logic  q_valid;
    logic  q_ready;
    t_item q_item;

    i2cbb_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_item)
    );

    i2cbb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_item  (q_item),
        .i_cfg   (i_cfg),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

// File: rtl/i2cbb_front.sv
`default_nettype none

module i2cbb_front #(
    parameter int DEPTH = i2cbb_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    i2cbb_cmd_if.sink         i_cmd,
    output logic              o_valid,
    input  logic              i_ready,
    output i2cbb_pkg::t_item  o_item
);
    import i2cbb_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    t_item              w_item;
    logic               push;
    logic               pop;

    // A word launches a command only if it is flagged and carries a known code.
    always_comb begin
        w_item.launch     = i_cmd.cmd_valid && (i_cmd.action <= ACT_WAIT_ACK);
        w_item.action     = i_cmd.action;
        w_item.tx_byte    = i_cmd.tx_byte;
        w_item.sda_sample = i_cmd.sda_sample;
    end

    assign i_cmd.ready = (r_count != CNT_W'(DEPTH));
    assign push        = i_cmd.valid && i_cmd.ready;
    assign o_valid     = (r_count != '0);
    assign pop         = o_valid && i_ready;
    assign o_item      = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        n_count = r_count + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count exceeds depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_count == $past(r_count) + CNT_W'($past(push)) - CNT_W'($past(pop)))
        else $error("queue count does not follow push and pop");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr == r_rd_ptr) |-> (r_count == '0 || r_count == CNT_W'(DEPTH)))
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// File: rtl/i2cbb_back.sv
`default_nettype none

module i2cbb_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  i2cbb_pkg::t_item  i_item,
    i2cbb_cfg_if.sink         i_cfg,
    i2cbb_res_if.source       o_res
);
    import i2cbb_pkg::*;

    localparam logic [4:0] PH_IDLE = 5'd0;
    localparam logic [4:0] PH_ST_A = 5'd1;
    localparam logic [4:0] PH_ST_B = 5'd2;
    localparam logic [4:0] PH_SP_A = 5'd3;
    localparam logic [4:0] PH_SP_B = 5'd4;
    localparam logic [4:0] PH_SP_C = 5'd5;
    localparam logic [4:0] PH_AK_A = 5'd6;
    localparam logic [4:0] PH_AK_B = 5'd7;
    localparam logic [4:0] PH_AK_C = 5'd8;
    localparam logic [4:0] PH_AK_D = 5'd9;
    localparam logic [4:0] PH_WR_D = 5'd10;
    localparam logic [4:0] PH_WR_H = 5'd11;
    localparam logic [4:0] PH_WR_L = 5'd12;
    localparam logic [4:0] PH_RD_R = 5'd13;
    localparam logic [4:0] PH_RD_L = 5'd14;
    localparam logic [4:0] PH_RD_H = 5'd15;
    localparam logic [4:0] PH_WA_A = 5'd16;
    localparam logic [4:0] PH_WA_B = 5'd17;
    localparam logic [4:0] PH_WA_C = 5'd18;
    localparam logic [4:0] PH_WA_D = 5'd19;
    localparam logic [4:0] PH_WA_E = 5'd20;
    localparam logic [4:0] PH_WA_F = 5'd21;
    localparam logic [4:0] PH_WA_P = 5'd22;
    localparam logic [4:0] PH_WA_Q = 5'd23;

    logic [CFG_DATA_W-1:0] r_ticks_per_us;
    logic [CFG_DATA_W-1:0] r_ack_wait_limit;

    logic [4:0]           r_phase, n_phase;
    logic [BIT_IDX_W-1:0] r_bit_index, n_bit_index;
    logic [BYTE_W-1:0]    r_shift, n_shift;
    logic [DELAY_W-1:0]   r_delay, n_delay;
    logic [7:0]           r_poll, n_poll;
    logic                 r_scl, n_scl;
    logic                 r_sda, n_sda;
    logic                 r_drv, n_drv;
    logic [BYTE_W-1:0]    r_rx, n_rx;
    logic                 r_nack, n_nack;
    logic                 n_done;
    logic                 r_out_valid;
    t_res                 r_out;

    logic [7:0]           w_tick;
    logic [DELAY_W-1:0]   w_d1, w_d2, w_d4;
    logic [BIT_IDX_W-1:0] w_bit_next;
    logic [BYTE_W-1:0]    w_rd_shift;
    logic                 pop;

    assign o_ready = !r_out_valid || o_res.ready;
    assign pop     = i_valid && o_ready;

    // A tick rate of zero counts as one tick per microsecond.
    assign w_tick     = (r_ticks_per_us == '0) ? 8'd1 : r_ticks_per_us;
    assign w_d1       = {2'b00, w_tick};
    assign w_d2       = {1'b0, w_tick, 1'b0};
    assign w_d4       = {w_tick, 2'b00};
    assign w_bit_next = r_bit_index + BIT_IDX_W'(1);
    assign w_rd_shift = {r_shift[BYTE_W-2:0], i_item.sda_sample};

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_per_us   <= TICKS_PER_US_RST;
            r_ack_wait_limit <= ACK_WAIT_LIMIT_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_TICKS_PER_US:   r_ticks_per_us   <= i_cfg.data;
                CFG_ACK_WAIT_LIMIT: r_ack_wait_limit <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_bit_index = r_bit_index;
        n_shift     = r_shift;
        n_delay     = r_delay;
        n_poll      = r_poll;
        n_scl       = r_scl;
        n_sda       = r_sda;
        n_drv       = r_drv;
        n_rx        = r_rx;
        n_nack      = r_nack;
        n_done      = 1'b0;

        if (r_phase == PH_IDLE) begin
            if (i_item.launch) begin
                unique case (i_item.action) inside
                    ACT_START: begin
                        n_drv = 1'b1; n_sda = 1'b1; n_scl = 1'b1;
                        n_phase = PH_ST_A; n_delay = w_d4;
                    end
                    ACT_STOP: begin
                        n_drv = 1'b1; n_scl = 1'b0; n_sda = 1'b0;
                        n_phase = PH_SP_A; n_delay = w_d4;
                    end
                    ACT_WRITE: begin
                        n_drv = 1'b1; n_scl = 1'b0;
                        n_bit_index = '0;
                        n_sda = i_item.tx_byte[BYTE_W-1];
                        n_shift = {i_item.tx_byte[BYTE_W-2:0], 1'b0};
                        n_phase = PH_WR_D; n_delay = w_d2;
                    end
                    ACT_READ: begin
                        n_drv = 1'b0;
                        n_shift = '0;
                        n_bit_index = '0;
                        n_phase = PH_RD_R; n_delay = w_d1;
                    end
                    ACT_ACK, ACT_NACK: begin
                        n_drv = 1'b1; n_scl = 1'b0;
                        n_shift = {{(BYTE_W-1){1'b0}}, (i_item.action == ACT_NACK)};
                        n_phase = PH_AK_A; n_delay = w_d2;
                    end
                    ACT_WAIT_ACK: begin
                        n_drv = 1'b1; n_sda = 1'b1;
                        n_poll = r_ack_wait_limit;
                        n_phase = PH_WA_A; n_delay = w_d1;
                    end
                    default: ;
                endcase
            end
        end else if (r_delay > DELAY_W'(1)) begin
            n_delay = r_delay - DELAY_W'(1);
        end else begin
            n_delay = '0;
            unique case (r_phase) inside
                PH_ST_A: begin n_sda = 1'b0; n_phase = PH_ST_B; n_delay = w_d4; end
                PH_ST_B: begin n_scl = 1'b0; n_phase = PH_IDLE; n_done = 1'b1; end
                PH_SP_A: begin n_scl = 1'b1; n_phase = PH_SP_B; n_delay = w_d4; end
                PH_SP_B: begin n_sda = 1'b1; n_phase = PH_SP_C; n_delay = w_d4; end
                PH_SP_C: begin n_phase = PH_IDLE; n_done = 1'b1; end
                PH_AK_A: begin n_sda = r_shift[0]; n_phase = PH_AK_B; n_delay = w_d2; end
                PH_AK_B: begin n_scl = 1'b1; n_phase = PH_AK_C; n_delay = w_d2; end
                PH_AK_C: begin n_scl = 1'b0; n_phase = PH_AK_D; n_delay = w_d1; end
                PH_AK_D: begin n_phase = PH_IDLE; n_done = 1'b1; end
                PH_WR_D: begin n_scl = 1'b1; n_phase = PH_WR_H; n_delay = w_d2; end
                PH_WR_H: begin n_scl = 1'b0; n_phase = PH_WR_L; n_delay = w_d2; end
                PH_WR_L: begin
                    n_bit_index = w_bit_next;
                    if (w_bit_next < BIT_IDX_W'(BITS_PER_BYTE)) begin
                        n_sda = r_shift[BYTE_W-1];
                        n_shift = {r_shift[BYTE_W-2:0], 1'b0};
                        n_phase = PH_WR_D; n_delay = w_d2;
                    end else begin
                        n_phase = PH_IDLE; n_done = 1'b1;
                    end
                end
                PH_RD_R: begin n_scl = 1'b0; n_phase = PH_RD_L; n_delay = w_d2; end
                PH_RD_L: begin n_scl = 1'b1; n_phase = PH_RD_H; n_delay = w_d1; end
                PH_RD_H: begin
                    n_shift = w_rd_shift;
                    n_bit_index = w_bit_next;
                    n_scl = 1'b0;
                    if (w_bit_next < BIT_IDX_W'(BITS_PER_BYTE)) begin
                        n_phase = PH_RD_L; n_delay = w_d2;
                    end else begin
                        n_rx = w_rd_shift;
                        n_phase = PH_IDLE; n_done = 1'b1;
                    end
                end
                PH_WA_A: begin n_scl = 1'b0; n_phase = PH_WA_B; n_delay = w_d1; end
                PH_WA_B: begin n_drv = 1'b0; n_phase = PH_WA_C; n_delay = w_d1; end
                PH_WA_C, PH_WA_Q: begin
                    // Low SDA is an acknowledge; otherwise spend one poll.
                    if (!i_item.sda_sample) begin
                        n_phase = PH_WA_D;
                    end else begin
                        n_poll = r_poll - 8'd1;
                        n_phase = PH_WA_P;
                    end
                    n_delay = w_d1;
                end
                PH_WA_D: begin n_scl = 1'b1; n_phase = PH_WA_E; n_delay = w_d1; end
                PH_WA_E: begin n_scl = 1'b0; n_phase = PH_WA_F; n_delay = w_d1; end
                PH_WA_F: begin n_nack = 1'b0; n_phase = PH_IDLE; n_done = 1'b1; end
                PH_WA_P: begin
                    if (r_poll == '0) begin
                        n_scl = 1'b0; n_nack = 1'b1;
                        n_phase = PH_IDLE; n_done = 1'b1;
                    end else begin
                        n_phase = PH_WA_Q; n_delay = w_d1;
                    end
                end
                default: begin n_phase = PH_IDLE; n_done = 1'b1; end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bit_index <= '0;
            r_shift     <= '0;
            r_delay     <= '0;
            r_poll      <= '0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_drv       <= 1'b1;
            r_rx        <= '0;
            r_nack      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_phase     <= n_phase;
                r_bit_index <= n_bit_index;
                r_shift     <= n_shift;
                r_delay     <= n_delay;
                r_poll      <= n_poll;
                r_scl       <= n_scl;
                r_sda       <= n_sda;
                r_drv       <= n_drv;
                r_rx        <= n_rx;
                r_nack      <= n_nack;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out.scl_level <= n_scl;
            r_out.sda_level <= n_sda;
            r_out.sda_drive <= n_drv;
            r_out.busy_res  <= (n_phase != PH_IDLE);
            r_out.done_res  <= n_done;
            r_out.rx_byte   <= n_rx;
            r_out.no_ack    <= n_nack;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.scl_level = r_out.scl_level;
    assign o_res.sda_level = r_out.sda_level;
    assign o_res.sda_drive = r_out.sda_drive;
    assign o_res.busy_res  = r_out.busy_res;
    assign o_res.done_res  = r_out.done_res;
    assign o_res.rx_byte   = r_out.rx_byte;
    assign o_res.no_ack    = r_out.no_ack;

    a_idle_no_delay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_delay == '0))
        else $error("delay left over while idle");

    a_bit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_index <= BIT_IDX_W'(BITS_PER_BYTE))
        else $error("bit index past byte length");

    a_countdown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && r_phase != PH_IDLE && r_delay > DELAY_W'(1))
        |=> (r_delay == $past(r_delay) - DELAY_W'(1) && r_phase == $past(r_phase)))
        else $error("segment countdown skipped or changed phase");

    a_done_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> (r_out.done_res == ($past(r_phase) != PH_IDLE && r_phase == PH_IDLE)))
        else $error("done flag does not match command completion");

endmodule

`default_nettype wire

// File: tb/i2c_bit_bang_master_unit_tb.sv
module i2c_bit_bang_master_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cbb_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 50_000;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef enum logic [4:0] {
        P_IDLE,
        P_START_HOLD, P_START_LOW,
        P_STOP_A, P_STOP_B, P_STOP_C,
        P_ACK_A, P_ACK_B, P_ACK_C, P_ACK_D,
        P_WR_SETUP, P_WR_HIGH, P_WR_LOW,
        P_RD_REL, P_RD_LOW, P_RD_HIGH,
        P_WA_A, P_WA_B, P_WA_C, P_WA_D, P_WA_E, P_WA_F, P_WA_POLL, P_WA_NEXT
    } t_bus_phase;

    logic i_clk = 1'b0;
    logic i_rst_n;

    i2cbb_cmd_if cmd_ch ();
    i2cbb_cfg_if cfg_ch ();
    i2cbb_res_if res_ch ();

    i2c_bit_bang_master_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    always #5 i_clk = ~i_clk;

    // Sequencer copy kept in step with the words sent.
    logic [7:0]         bus_tpu;
    logic [7:0]         bus_limit;
    t_bus_phase         bus_phase;
    logic [3:0]         bus_bits;
    logic [7:0]         bus_shift;
    logic [DELAY_W-1:0] bus_delay;
    logic [7:0]         bus_polls;
    logic               bus_scl, bus_sda, bus_drv;
    logic [7:0]         bus_rx;
    logic               bus_nack;
    logic               bus_done;

    t_res        pending_pins[$];
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int unsigned word_count = 0;
    bit          calm = 1'b0;

    function automatic void hold_for(t_bus_phase ph, int unsigned us);
        int unsigned t;
        t = (bus_tpu == 8'd0) ? 1 : int'(bus_tpu);
        bus_phase = ph;
        bus_delay = DELAY_W'(us * t);
    endfunction

    function automatic void end_command();
        bus_phase = P_IDLE;
        bus_delay = '0;
        bus_done  = 1'b1;
    endfunction

    function automatic void shift_out_bit();
        bus_sda   = bus_shift[7];
        bus_shift = bus_shift << 1;
        hold_for(P_WR_SETUP, 2);
    endfunction

    function automatic void poll_sda(logic sda);
        if (!sda) begin
            hold_for(P_WA_D, 1);
        end else begin
            bus_polls = bus_polls - 8'd1;
            hold_for(P_WA_POLL, 1);
        end
    endfunction

    function automatic void begin_command(logic [ACTION_W-1:0] act, logic [7:0] tx_v);
        case (act) inside
            ACT_START: begin
                bus_drv = 1'b1; bus_sda = 1'b1; bus_scl = 1'b1;
                hold_for(P_START_HOLD, 4);
            end
            ACT_STOP: begin
                bus_drv = 1'b1; bus_scl = 1'b0; bus_sda = 1'b0;
                hold_for(P_STOP_A, 4);
            end
            ACT_WRITE: begin
                bus_drv = 1'b1; bus_scl = 1'b0;
                bus_shift = tx_v;
                bus_bits = '0;
                shift_out_bit();
            end
            ACT_READ: begin
                bus_drv = 1'b0;
                bus_shift = '0;
                bus_bits = '0;
                hold_for(P_RD_REL, 1);
            end
            ACT_ACK, ACT_NACK: begin
                bus_drv = 1'b1; bus_scl = 1'b0;
                bus_shift = (act == ACT_NACK) ? 8'd1 : 8'd0;
                hold_for(P_ACK_A, 2);
            end
            ACT_WAIT_ACK: begin
                bus_drv = 1'b1; bus_sda = 1'b1;
                bus_polls = bus_limit;
                hold_for(P_WA_A, 1);
            end
            default: ;
        endcase
    endfunction

    function automatic void advance_phase(logic sda);
        case (bus_phase)
            P_START_HOLD: begin bus_sda = 1'b0; hold_for(P_START_LOW, 4); end
            P_START_LOW:  begin bus_scl = 1'b0; end_command(); end
            P_STOP_A:     begin bus_scl = 1'b1; hold_for(P_STOP_B, 4); end
            P_STOP_B:     begin bus_sda = 1'b1; hold_for(P_STOP_C, 4); end
            P_STOP_C:     end_command();
            P_ACK_A:      begin bus_sda = bus_shift[0]; hold_for(P_ACK_B, 2); end
            P_ACK_B:      begin bus_scl = 1'b1; hold_for(P_ACK_C, 2); end
            P_ACK_C:      begin bus_scl = 1'b0; hold_for(P_ACK_D, 1); end
            P_ACK_D:      end_command();
            P_WR_SETUP:   begin bus_scl = 1'b1; hold_for(P_WR_HIGH, 2); end
            P_WR_HIGH:    begin bus_scl = 1'b0; hold_for(P_WR_LOW, 2); end
            P_WR_LOW: begin
                bus_bits = bus_bits + 4'd1;
                if (bus_bits < BITS_PER_BYTE) shift_out_bit();
                else end_command();
            end
            P_RD_REL:     begin bus_scl = 1'b0; hold_for(P_RD_LOW, 2); end
            P_RD_LOW:     begin bus_scl = 1'b1; hold_for(P_RD_HIGH, 1); end
            P_RD_HIGH: begin
                bus_shift = {bus_shift[6:0], sda};
                bus_bits = bus_bits + 4'd1;
                bus_scl = 1'b0;
                if (bus_bits < BITS_PER_BYTE) begin
                    hold_for(P_RD_LOW, 2);
                end else begin
                    bus_rx = bus_shift;
                    end_command();
                end
            end
            P_WA_A:       begin bus_scl = 1'b0; hold_for(P_WA_B, 1); end
            P_WA_B:       begin bus_drv = 1'b0; hold_for(P_WA_C, 1); end
            P_WA_C:       poll_sda(sda);
            P_WA_D:       begin bus_scl = 1'b1; hold_for(P_WA_E, 1); end
            P_WA_E:       begin bus_scl = 1'b0; hold_for(P_WA_F, 1); end
            P_WA_F:       begin bus_nack = 1'b0; end_command(); end
            P_WA_POLL: begin
                // The poll counter is checked only after it was decremented.
                if (bus_polls == 8'd0) begin
                    bus_scl = 1'b0;
                    bus_nack = 1'b1;
                    end_command();
                end else begin
                    hold_for(P_WA_NEXT, 1);
                end
            end
            P_WA_NEXT:    poll_sda(sda);
            default:      end_command();
        endcase
    endfunction

    function automatic t_res bus_tick(t_item w);
        t_res r;
        bus_done = 1'b0;
        if (bus_phase == P_IDLE) begin
            if (w.launch && w.action != ACT_UNUSED) begin_command(w.action, w.tx_byte);
        end else if (bus_delay > 1) begin
            bus_delay = bus_delay - 1'b1;
        end else begin
            bus_delay = '0;
            advance_phase(w.sda_sample);
        end
        r.scl_level = bus_scl;
        r.sda_level = bus_sda;
        r.sda_drive = bus_drv;
        r.busy_res  = (bus_phase != P_IDLE);
        r.done_res  = bus_done;
        r.rx_byte   = bus_rx;
        r.no_ack    = bus_nack;
        return r;
    endfunction

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            if (pending_pins.size() == 0) begin
                $error("result word arrived with no expected word pending");
                mismatches++;
            end else begin
                want = pending_pins.pop_front();
                check_field("scl_level", want.scl_level, res_ch.scl_level);
                check_field("sda_level", want.sda_level, res_ch.sda_level);
                check_field("sda_drive", want.sda_drive, res_ch.sda_drive);
                check_field("busy_res", want.busy_res, res_ch.busy_res);
                check_field("done_res", want.done_res, res_ch.done_res);
                check_field("rx_byte", want.rx_byte, res_ch.rx_byte);
                check_field("no_ack", want.no_ack, res_ch.no_ack);
            end
        end
    end

    always @(negedge i_clk) begin
        res_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 21);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(t_item w);
        while (!calm && $urandom_range(99) < 21) begin
            cmd_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.valid      <= 1'b1;
        cmd_ch.cmd_valid  <= w.launch;
        cmd_ch.action     <= w.action;
        cmd_ch.tx_byte    <= w.tx_byte;
        cmd_ch.sda_sample <= w.sda_sample;
        pending_pins.push_back(bus_tick(w));
        word_count++;
        @(posedge i_clk);
        while (cmd_ch.ready !== 1'b1) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Words offered while the sequencer is idle that must not start anything.
    task automatic idle_words(int n);
        t_item w;
        repeat (n) begin
            w.launch     = ($urandom_range(4) == 0);
            w.action     = w.launch ? ACT_UNUSED : ACTION_W'($urandom_range(7));
            w.tx_byte    = 8'($urandom);
            w.sda_sample = 1'($urandom_range(1));
            send_word(w);
        end
    endtask

    // Issue one command, then tick the bus until the command has finished.
    // one_pct is the chance in percent that SDA reads high on each tick.
    task automatic run_cmd(logic [ACTION_W-1:0] act, logic [7:0] tx_v, int one_pct);
        t_item w;
        w.launch     = 1'b1;
        w.action     = act;
        w.tx_byte    = tx_v;
        w.sda_sample = 1'($urandom_range(1));
        send_word(w);
        while (bus_phase != P_IDLE) begin
            // Commands offered while busy must be ignored.
            w.launch     = ($urandom_range(19) == 0);
            w.action     = ACTION_W'($urandom_range(7));
            w.tx_byte    = 8'($urandom);
            w.sda_sample = ($urandom_range(99) < one_pct);
            send_word(w);
        end
        if ($urandom_range(3) == 0) idle_words($urandom_range(1, 3));
    endtask

    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending_pins.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge i_clk);
        while (cfg_ch.ready !== 1'b1) @(posedge i_clk);
        if (idx == CFG_TICKS_PER_US) bus_tpu = val;
        else if (idx == CFG_ACK_WAIT_LIMIT) bus_limit = val;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic int ack_one_pct();
        int r;
        r = $urandom_range(99);
        if (r < 70) return 30;
        if (r < 85) return 97;
        return 100;
    endfunction

    task automatic test_idle_after_reset();
        idle_words(6);
    endtask

    task automatic test_each_command();
        run_cmd(ACT_START, 8'h00, 50);
        run_cmd(ACT_WRITE, 8'hA5, 50);
        run_cmd(ACT_WAIT_ACK, 8'h5A, 0);
        run_cmd(ACT_READ, 8'h00, 50);
        run_cmd(ACT_ACK, 8'hFF, 50);
        run_cmd(ACT_NACK, 8'h00, 50);
        run_cmd(ACT_WAIT_ACK, 8'h00, 30);
        run_cmd(ACT_STOP, 8'h00, 50);
        run_cmd(ACT_UNUSED, 8'hFF, 50);
    endtask

    task automatic test_register_extremes();
        drain_results();
        write_reg(CFG_TICKS_PER_US, 8'd3);
        write_reg(CFG_ACK_WAIT_LIMIT, 8'd1);
        run_cmd(ACT_WAIT_ACK, 8'h00, 100);
        run_cmd(ACT_WAIT_ACK, 8'h00, 0);
        run_cmd(ACT_NACK, 8'h00, 50);
        // Zero ticks acts as one; a zero poll limit wraps instead of ending early.
        drain_results();
        write_reg(CFG_TICKS_PER_US, 8'd0);
        write_reg(CFG_ACK_WAIT_LIMIT, 8'd0);
        run_cmd(ACT_WAIT_ACK, 8'h00, 30);
        run_cmd(ACT_READ, 8'h00, 50);
        drain_results();
        write_reg(CFG_TICKS_PER_US, 8'd1);
        write_reg(CFG_ACK_WAIT_LIMIT, 8'd2);
        run_cmd(ACT_WAIT_ACK, 8'h00, 100);
    endtask

    task automatic test_spare_registers();
        drain_results();
        write_reg(CFG_SPARE_2, 8'($urandom));
        write_reg(CFG_SPARE_3, 8'($urandom));
        run_cmd(ACT_START, 8'h00, 50);
        run_cmd(ACT_WAIT_ACK, 8'h00, 100);
    endtask

    task automatic one_transaction();
        logic [7:0] addr;
        int         n;
        addr = 8'($urandom);
        n = $urandom_range(1, 2);
        run_cmd(ACT_START, 8'($urandom), 50);
        run_cmd(ACT_WRITE, addr, 50);
        run_cmd(ACT_WAIT_ACK, 8'($urandom), ack_one_pct());
        for (int k = 0; k < n; k++) begin
            if (addr[0]) begin
                run_cmd(ACT_READ, 8'($urandom), $urandom_range(100));
                run_cmd((k == n - 1) ? ACT_NACK : ACT_ACK, 8'($urandom), 50);
            end else begin
                run_cmd(ACT_WRITE, 8'($urandom), 50);
                run_cmd(ACT_WAIT_ACK, 8'($urandom), ack_one_pct());
            end
        end
        run_cmd(ACT_STOP, 8'($urandom), 50);
    endtask

    task automatic noise_commands();
        case ($urandom_range(2))
            0: run_cmd(ACTION_W'($urandom_range(7)), 8'($urandom), $urandom_range(100));
            1: begin
                run_cmd(ACT_START, 8'($urandom), 50);
                run_cmd(ACT_STOP, 8'($urandom), 50);
            end
            default: begin
                run_cmd(ACT_READ, 8'($urandom), $urandom_range(100));
                run_cmd(ACT_WAIT_ACK, 8'($urandom), ack_one_pct());
            end
        endcase
    endtask

    // Runs random bus traffic until about target input words have been sent.
    task automatic random_phase(int target, logic [7:0] tpu, logic [7:0] lim, bit pause_midway);
        int unsigned first;
        bit          paused;
        paused = 1'b0;
        drain_results();
        write_reg(CFG_TICKS_PER_US, tpu);
        write_reg(CFG_ACK_WAIT_LIMIT, lim);
        first = word_count;
        while (word_count - first < target) begin
            if ($urandom_range(1) == 0) noise_commands();
            else one_transaction();
            if (pause_midway && !paused && word_count - first >= target / 2) begin
                // Let the pipeline run dry before sending more.
                drain_results();
                paused = 1'b1;
            end
        end
    endtask

    task automatic test_random_transactions();
        calm = 1'b1;
        random_phase(90, 8'd1, 8'($urandom_range(1, 6)), 1'b0);
        calm = 1'b0;
        random_phase(90, 8'($urandom_range(1, 2)), 8'($urandom_range(1, 6)), 1'b1);
        random_phase(70, 8'($urandom_range(0, 1)), 8'($urandom_range(1, 6)), 1'b0);
    endtask

    initial begin
        i_rst_n           = 1'b0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.cmd_valid  = 1'b0;
        cmd_ch.action     = ACT_START;
        cmd_ch.tx_byte    = '0;
        cmd_ch.sda_sample = 1'b1;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = CFG_TICKS_PER_US;
        cfg_ch.data       = '0;
        res_ch.ready      = 1'b0;

        bus_tpu   = TICKS_PER_US_RST;
        bus_limit = ACK_WAIT_LIMIT_RST;
        bus_phase = P_IDLE;
        bus_bits  = '0;
        bus_shift = '0;
        bus_delay = '0;
        bus_polls = '0;
        bus_scl   = 1'b1;
        bus_sda   = 1'b1;
        bus_drv   = 1'b1;
        bus_rx    = '0;
        bus_nack  = 1'b0;
        bus_done  = 1'b0;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_idle_after_reset();
        test_each_command();
        test_register_extremes();
        test_spare_registers();
        test_random_transactions();

        drain_results();
        repeat (8) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
